// ----- rtl/session_supervisor_backoff_assert.svh -----
// Assertion macros for the session supervisor block.
`ifndef SESSION_SUPERVISOR_BACKOFF_ASSERT_SVH
`define SESSION_SUPERVISOR_BACKOFF_ASSERT_SVH

// Same-cycle implication on aclk, idle while aresetn is low.
`define SSB_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication on aclk, idle while aresetn is low.
`define SSB_ASSERT_NXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/ssb_pkg.sv -----
// Shared types, widths and codes of the session supervisor.
`default_nettype none

package ssb_pkg;

    localparam int TIME_WIDTH_DEF = 48;

    localparam int ACT_W    = 4;
    localparam int TTL_W    = 16;
    localparam int NOW_W    = 48;
    localparam int RND_W    = 32;
    localparam int CEIL_W   = 32;
    localparam int CMD_W    = 2;
    localparam int ST_W     = 3;
    localparam int MS_W     = 19;
    localparam int CAP_W    = MS_W + 1;
    localparam int MARGIN_W = 9;
    localparam int FCNT_W   = 5;
    localparam int RDLY_W   = 22;
    localparam int CIDX_W   = 2;
    localparam int BCNT_W   = $clog2(RND_W);

    localparam logic [MS_W-1:0]     BACKOFF_LIMIT_MS = MS_W'(300000);
    localparam logic [MS_W-1:0]     BACKOFF_FLOOR_MS = MS_W'(1);
    localparam logic [MS_W-1:0]     BACKOFF_MIN_RST  = MS_W'(1000);
    localparam logic [MS_W-1:0]     BACKOFF_MAX_RST  = MS_W'(60000);
    localparam logic [MARGIN_W-1:0] MARGIN_LOW       = MARGIN_W'(5);
    localparam logic [MARGIN_W-1:0] MARGIN_HIGH      = MARGIN_W'(300);
    localparam logic [MARGIN_W-1:0] MARGIN_RST       = MARGIN_W'(30);
    localparam logic [TTL_W-1:0]    TTL_LOW          = TTL_W'(60);
    localparam logic [TTL_W-1:0]    TTL_HIGH         = TTL_W'(3600);
    localparam logic [9:0]          MS_PER_S         = 10'd1000;
    localparam logic [9:0]          MS_PER_HALF_S    = 10'd500;
    localparam logic [RDLY_W-1:0]   MIN_REFRESH_MS   = RDLY_W'(1000);
    localparam logic [FCNT_W-1:0]   FAIL_SAT         = FCNT_W'(31);

    // register indexes
    localparam logic [CIDX_W-1:0] REG_BACKOFF_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BACKOFF_MAX = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MARGIN      = 2'd2;

    // events
    localparam logic [ACT_W-1:0] ACT_NET       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CRED      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_DENIED    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_CHANGED   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_STARTFAIL = 4'd4;
    localparam logic [ACT_W-1:0] ACT_READY     = 4'd5;
    localparam logic [ACT_W-1:0] ACT_DISC      = 4'd6;
    localparam logic [ACT_W-1:0] ACT_STOPPED   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_POLL      = 4'd8;
    localparam logic [ACT_W-1:0] ACT_WAIT      = 4'd9;

    // supervisor states
    localparam logic [ST_W-1:0] ST_WAITNET  = 3'd0;
    localparam logic [ST_W-1:0] ST_REFRESH  = 3'd1;
    localparam logic [ST_W-1:0] ST_START    = 3'd2;
    localparam logic [ST_W-1:0] ST_ONLINE   = 3'd3;
    localparam logic [ST_W-1:0] ST_STOPPING = 3'd4;
    localparam logic [ST_W-1:0] ST_BACKOFF  = 3'd5;
    localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd6;

    // commands
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [FCNT_W-1:0] fail_count;
        logic [MS_W-1:0]   min_ms;
        logic [MS_W-1:0]   max_ms;
        logic [RND_W-1:0]  rnd;
    } jit_req_t;

    typedef struct packed {
        logic            busy;
        logic [MS_W-1:0] delay_ms;
    } jit_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ssb_backoff.sv -----
// Jittered backoff delay unit: serial cap doubling, then bit-serial modulo.
`default_nettype none

module ssb_backoff
    import ssb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire jit_req_t req,
    output jit_rsp_t      rsp
);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_CAP  = 2'd1;
    localparam logic [1:0] U_MOD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [CAP_W-1:0]  hi_reg, hi_next;
    logic [FCNT_W-1:0] n_reg, n_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [CAP_W-1:0]  rem_reg, rem_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic [MS_W-1:0]   delay_reg, delay_next;

    logic [CAP_W-1:0] cap_dbl;
    logic [CAP_W-1:0] cap_lo;
    logic [CAP_W-1:0] divisor;
    logic [CAP_W-1:0] rem_sh;
    logic [CAP_W-1:0] rem_new;
    logic [CAP_W-1:0] delay_sum;

    always_comb begin
        cap_dbl   = {cap_reg[CAP_W-2:0], 1'b0};
        cap_lo    = cap_reg >> 1;
        divisor   = cap_reg - cap_lo + CAP_W'(1);
        // remainder stays below the divisor, so the top bit is free to shift out
        rem_sh    = {rem_reg[CAP_W-2:0], rnd_reg[RND_W-1]};
        rem_new   = (rem_sh >= divisor) ? (rem_sh - divisor) : rem_sh;
        delay_sum = cap_lo + rem_new;
    end

    always_comb begin
        state_next = state_reg;
        cap_next   = cap_reg;
        hi_next    = hi_reg;
        n_next     = n_reg;
        rnd_next   = rnd_reg;
        rem_next   = rem_reg;
        bcnt_next  = bcnt_reg;
        delay_next = delay_reg;
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    cap_next   = {1'b0, req.min_ms};
                    hi_next    = (req.max_ms < req.min_ms) ? {1'b0, req.min_ms}
                                                           : {1'b0, req.max_ms};
                    n_next     = req.fail_count;
                    rnd_next   = req.rnd;
                    state_next = U_CAP;
                end
            end
            U_CAP: begin
                if (n_reg != '0 && cap_reg < hi_reg) begin
                    cap_next = (cap_dbl > hi_reg) ? hi_reg : cap_dbl;
                    n_next   = n_reg - FCNT_W'(1);
                end else begin
                    rem_next   = '0;
                    bcnt_next  = BCNT_W'(RND_W - 1);
                    state_next = U_MOD;
                end
            end
            U_MOD: begin
                rem_next = rem_new;
                rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
                if (bcnt_reg == '0) begin
                    delay_next = delay_sum[MS_W-1:0];
                    state_next = U_IDLE;
                end else begin
                    bcnt_next = bcnt_reg - BCNT_W'(1);
                end
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cap_reg   <= cap_next;
        hi_reg    <= hi_next;
        n_reg     <= n_next;
        rnd_reg   <= rnd_next;
        rem_reg   <= rem_next;
        bcnt_reg  <= bcnt_next;
        delay_reg <= delay_next;
    end

    assign rsp.busy     = (state_reg != U_IDLE);
    assign rsp.delay_ms = delay_reg;

endmodule

`default_nettype wire

// ----- rtl/session_supervisor_backoff.sv -----
// Session supervisor top level: event decode, deadlines and result register.
//
//  channel    | direction | handshake          | payload
//  s_ (event) | in        | s_valid / s_ready  | action, flag, TTLs, now, random, ceiling
//  m_ (word)  | out       | m_valid / m_ready  | command, went_online, wait, state
//  cfg_       | in        | cfg_wr_en          | cfg_index, cfg_wr_data (no read-back)
//
// A plain event passes through accept, decode and commit, and result load before the next
// accept; the result word is registered at the result load. A good credential adds a
// deadline-add step. A failure with the network up adds the backoff unit's steps: F (0..19)
// cap doublings, one exit check, 32 modulo steps and one step to hand the delay back.
// Reset sets state, deadlines, failure count, config and m_valid only; no clearing pass.
// A result held under a low m_ready stalls the result load, and no new word is taken.
`default_nettype none

module session_supervisor_backoff
    import ssb_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [MS_W-1:0]     cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [ACT_W-1:0]    s_action,
    input  wire logic                s_event_flag,
    input  wire logic [TTL_W-1:0]    s_voice_ttl_s,
    input  wire logic [TTL_W-1:0]    s_agent_ttl_s,
    input  wire logic [NOW_W-1:0]    s_now_ms,
    input  wire logic [RND_W-1:0]    s_random_word,
    input  wire logic [CEIL_W-1:0]   s_ceiling_ms,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [CMD_W-1:0]         m_command,
    output logic                     m_went_online,
    output logic [CEIL_W-1:0]        m_wait_left_ms,
    output logic [ST_W-1:0]          m_state_now
);

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_EVAL   = 3'd1;
    localparam logic [2:0] T_JIT    = 3'd2;
    localparam logic [2:0] T_REFADD = 3'd3;
    localparam logic [2:0] T_DONE   = 3'd4;

    // configuration
    logic [MS_W-1:0]     bmin_reg;
    logic [MS_W-1:0]     bmax_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [MS_W-1:0]     cfg_ms_clamped;
    logic [MARGIN_W-1:0] cfg_margin_clamped;

    // captured word
    logic [ACT_W-1:0]  act_reg;
    logic              flag_reg;
    logic [TTL_W-1:0]  vttl_reg;
    logic [TTL_W-1:0]  attl_reg;
    logic [NOW_W-1:0]  now_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [CEIL_W-1:0] ceil_reg;

    // supervisor state
    logic [2:0]            fsm_reg, fsm_next;
    logic [ST_W-1:0]       ctrl_reg, ctrl_next;
    logic [ST_W-1:0]       after_reg, after_next;
    logic                  net_reg, net_next;
    logic [FCNT_W-1:0]     fail_cnt_reg, fail_cnt_next;
    logic [TIME_WIDTH-1:0] retry_dl_reg, retry_dl_next;
    logic [TIME_WIDTH-1:0] refresh_dl_reg, refresh_dl_next;
    logic [RDLY_W-1:0]     ref_delay_reg, ref_delay_next;

    // pending result
    logic [CMD_W-1:0]  pend_cmd_reg, pend_cmd_next;
    logic              pend_onl_reg, pend_onl_next;
    logic [CEIL_W-1:0] pend_wait_reg, pend_wait_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic [CMD_W-1:0]  m_cmd_reg, m_cmd_next;
    logic              m_onl_reg, m_onl_next;
    logic [CEIL_W-1:0] m_wait_reg, m_wait_next;
    logic [ST_W-1:0]   m_state_reg, m_state_next;

    // decode results
    logic [ST_W-1:0]   d_ctrl, d_after, d_fail_tgt;
    logic              d_net, d_jit, d_refadd, d_clear;
    logic [CMD_W-1:0]  d_cmd;
    logic              d_onl;
    logic [CEIL_W-1:0] d_wait;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] dl_sel;
    logic [TIME_WIDTH-1:0] dl_diff;
    logic [TIME_WIDTH-1:0] ceil_t;
    logic                  ttl_ok;
    logic [TTL_W-1:0]      ttl_min;
    logic [11:0]           ttl_base;
    logic [9:0]            ttl_scale;
    logic [RDLY_W-1:0]     ttl_ms;

    jit_req_t jit_req;
    jit_rsp_t jit_rsp;
    logic     out_free;

    assign now_t  = TIME_WIDTH'(64'(now_reg));
    assign ceil_t = TIME_WIDTH'(ceil_reg);

    // config clamp
    always_comb begin
        if (cfg_wr_data < BACKOFF_FLOOR_MS) begin
            cfg_ms_clamped = BACKOFF_FLOOR_MS;
        end else if (cfg_wr_data > BACKOFF_LIMIT_MS) begin
            cfg_ms_clamped = BACKOFF_LIMIT_MS;
        end else begin
            cfg_ms_clamped = cfg_wr_data;
        end
        if (cfg_wr_data < MS_W'(MARGIN_LOW)) begin
            cfg_margin_clamped = MARGIN_LOW;
        end else if (cfg_wr_data > MS_W'(MARGIN_HIGH)) begin
            cfg_margin_clamped = MARGIN_HIGH;
        end else begin
            cfg_margin_clamped = cfg_wr_data[MARGIN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bmin_reg   <= BACKOFF_MIN_RST;
            bmax_reg   <= BACKOFF_MAX_RST;
            margin_reg <= MARGIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BACKOFF_MIN: bmin_reg   <= cfg_ms_clamped;
                REG_BACKOFF_MAX: bmax_reg   <= cfg_ms_clamped;
                REG_MARGIN:      margin_reg <= cfg_margin_clamped;
                default: begin
                end
            endcase
        end
    end

    // refresh delay: (min TTL - margin) s, or half the min TTL, at least one second
    always_comb begin
        ttl_ok  = (vttl_reg >= TTL_LOW) && (vttl_reg <= TTL_HIGH) &&
                  (attl_reg >= TTL_LOW) && (attl_reg <= TTL_HIGH);
        ttl_min = (vttl_reg < attl_reg) ? vttl_reg : attl_reg;
        if (ttl_min > TTL_W'(margin_reg)) begin
            ttl_base  = 12'(ttl_min - TTL_W'(margin_reg));
            ttl_scale = MS_PER_S;
        end else begin
            ttl_base  = ttl_min[11:0];
            ttl_scale = MS_PER_HALF_S;
        end
        ttl_ms = RDLY_W'(ttl_base * ttl_scale);
        ref_delay_next = (ttl_ms < MIN_REFRESH_MS) ? MIN_REFRESH_MS : ttl_ms;
    end

    // event decode
    always_comb begin
        d_ctrl     = ctrl_reg;
        d_after    = after_reg;
        d_net      = net_reg;
        d_jit      = 1'b0;
        d_refadd   = 1'b0;
        d_clear    = 1'b0;
        d_cmd      = CMD_NONE;
        d_onl      = 1'b0;
        d_wait     = '0;
        d_fail_tgt = net_reg ? ST_BACKOFF : ST_WAITNET;
        dl_sel     = (ctrl_reg == ST_BACKOFF) ? retry_dl_reg : refresh_dl_reg;
        dl_diff    = dl_sel - now_t;
        unique case (act_reg)
            ACT_NET: begin
                d_net = flag_reg;
                if (!flag_reg) begin
                    if (ctrl_reg == ST_START || ctrl_reg == ST_ONLINE) begin
                        d_ctrl  = ST_STOPPING;
                        d_after = ST_WAITNET;
                        d_cmd   = CMD_STOP;
                    end else if (ctrl_reg == ST_STOPPING) begin
                        d_after = ST_WAITNET;
                    end else begin
                        d_ctrl = ST_WAITNET;
                    end
                end else if (ctrl_reg == ST_WAITNET) begin
                    d_ctrl = ST_REFRESH;
                    d_cmd  = CMD_REFRESH;
                end else if (ctrl_reg == ST_STOPPING && after_reg == ST_WAITNET) begin
                    d_after = ST_REFRESH;
                end
            end
            ACT_CRED: begin
                if (ctrl_reg == ST_REFRESH) begin
                    if (!flag_reg || !ttl_ok) begin
                        d_ctrl = d_fail_tgt;
                        d_jit  = net_reg;
                    end else begin
                        d_refadd = 1'b1;
                        d_ctrl   = ST_START;
                        d_cmd    = CMD_START;
                    end
                end
            end
            ACT_DENIED: begin
                if (ctrl_reg == ST_REFRESH) begin
                    d_ctrl  = ST_BLOCKED;
                    d_clear = 1'b1;
                end
            end
            ACT_CHANGED: begin
                if (net_reg && ctrl_reg == ST_BLOCKED) begin
                    d_ctrl = ST_REFRESH;
                    d_cmd  = CMD_REFRESH;
                end
            end
            ACT_STARTFAIL: begin
                if (ctrl_reg == ST_START) begin
                    d_jit = net_reg;
                    if (flag_reg) begin
                        d_ctrl  = ST_STOPPING;
                        d_after = d_fail_tgt;
                        d_cmd   = CMD_STOP;
                    end else begin
                        d_ctrl = d_fail_tgt;
                    end
                end
            end
            ACT_READY: begin
                if (ctrl_reg == ST_START) begin
                    d_ctrl = ST_ONLINE;
                    d_onl  = 1'b1;
                end
            end
            ACT_DISC: begin
                if (ctrl_reg == ST_START || ctrl_reg == ST_ONLINE) begin
                    d_jit   = net_reg;
                    d_after = d_fail_tgt;
                    d_ctrl  = ST_STOPPING;
                    d_cmd   = CMD_STOP;
                end
            end
            ACT_STOPPED: begin
                if (ctrl_reg == ST_STOPPING) begin
                    d_ctrl = after_reg;
                    if (after_reg == ST_REFRESH) begin
                        d_cmd = CMD_REFRESH;
                    end
                end
            end
            ACT_POLL: begin
                if (net_reg) begin
                    if (ctrl_reg == ST_BACKOFF && now_t >= retry_dl_reg) begin
                        d_ctrl = ST_REFRESH;
                        d_cmd  = CMD_REFRESH;
                    end else if ((ctrl_reg == ST_START || ctrl_reg == ST_ONLINE) &&
                                 now_t >= refresh_dl_reg) begin
                        d_ctrl  = ST_STOPPING;
                        d_after = ST_REFRESH;
                        d_cmd   = CMD_STOP;
                    end
                end
            end
            ACT_WAIT: begin
                if (ceil_reg == '0) begin
                    d_wait = '0;
                end else if (ctrl_reg != ST_BACKOFF && ctrl_reg != ST_START &&
                             ctrl_reg != ST_ONLINE) begin
                    d_wait = ceil_reg;
                end else if (dl_sel <= now_t) begin
                    d_wait = '0;
                end else if (dl_diff < ceil_t) begin
                    d_wait = dl_diff[CEIL_W-1:0];
                end else begin
                    d_wait = ceil_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        fsm_next        = fsm_reg;
        ctrl_next       = ctrl_reg;
        after_next      = after_reg;
        net_next        = net_reg;
        fail_cnt_next   = fail_cnt_reg;
        retry_dl_next   = retry_dl_reg;
        refresh_dl_next = refresh_dl_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_onl_next   = pend_onl_reg;
        pend_wait_next  = pend_wait_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cmd_next      = m_cmd_reg;
        m_onl_next      = m_onl_reg;
        m_wait_next     = m_wait_reg;
        m_state_next    = m_state_reg;
        jit_req.start      = 1'b0;
        jit_req.fail_count = fail_cnt_reg;
        jit_req.min_ms     = bmin_reg;
        jit_req.max_ms     = bmax_reg;
        jit_req.rnd        = rnd_reg;
        unique case (fsm_reg)
            T_IDLE: begin
                if (s_valid) begin
                    fsm_next = T_EVAL;
                end
            end
            T_EVAL: begin
                ctrl_next      = d_ctrl;
                after_next     = d_after;
                net_next       = d_net;
                pend_cmd_next  = d_cmd;
                pend_onl_next  = d_onl;
                pend_wait_next = d_wait;
                if (d_clear || d_onl) begin
                    fail_cnt_next = '0;
                end
                if (d_clear) begin
                    retry_dl_next = '0;
                end
                if (d_jit) begin
                    jit_req.start = 1'b1;
                    fsm_next      = T_JIT;
                end else if (d_refadd) begin
                    fsm_next = T_REFADD;
                end else begin
                    fsm_next = T_DONE;
                end
            end
            T_JIT: begin
                if (!jit_rsp.busy) begin
                    retry_dl_next = now_t + TIME_WIDTH'(jit_rsp.delay_ms);
                    if (fail_cnt_reg != FAIL_SAT) begin
                        fail_cnt_next = fail_cnt_reg + FCNT_W'(1);
                    end
                    fsm_next = T_DONE;
                end
            end
            T_REFADD: begin
                refresh_dl_next = now_t + TIME_WIDTH'(ref_delay_reg);
                fsm_next        = T_DONE;
            end
            T_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_cmd_next   = pend_cmd_reg;
                    m_onl_next   = pend_onl_reg;
                    m_wait_next  = pend_wait_reg;
                    m_state_next = ctrl_reg;
                    fsm_next     = T_IDLE;
                end
            end
            default: begin
                fsm_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= T_IDLE;
            ctrl_reg       <= ST_WAITNET;
            after_reg      <= ST_WAITNET;
            net_reg        <= 1'b0;
            fail_cnt_reg   <= '0;
            retry_dl_reg   <= '0;
            refresh_dl_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            fsm_reg        <= fsm_next;
            ctrl_reg       <= ctrl_next;
            after_reg      <= after_next;
            net_reg        <= net_next;
            fail_cnt_reg   <= fail_cnt_next;
            retry_dl_reg   <= retry_dl_next;
            refresh_dl_reg <= refresh_dl_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_cmd_reg  <= pend_cmd_next;
        pend_onl_reg  <= pend_onl_next;
        pend_wait_reg <= pend_wait_next;
        m_cmd_reg     <= m_cmd_next;
        m_onl_reg     <= m_onl_next;
        m_wait_reg    <= m_wait_next;
        m_state_reg   <= m_state_next;
        if (fsm_reg == T_EVAL) begin
            ref_delay_reg <= ref_delay_next;
        end
        // capture the word on accept
        if (s_valid && s_ready) begin
            act_reg  <= s_action;
            flag_reg <= s_event_flag;
            vttl_reg <= s_voice_ttl_s;
            attl_reg <= s_agent_ttl_s;
            now_reg  <= s_now_ms;
            rnd_reg  <= s_random_word;
            ceil_reg <= s_ceiling_ms;
        end
    end

    ssb_backoff u_backoff (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (jit_req),
        .rsp     (jit_rsp)
    );

    assign s_ready        = (fsm_reg == T_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_command      = m_cmd_reg;
    assign m_went_online  = m_onl_reg;
    assign m_wait_left_ms = m_wait_reg;
    assign m_state_now    = m_state_reg;

`include "session_supervisor_backoff_assert.svh"

    `SSB_ASSERT_NXT(a_accept_blocks, s_valid && s_ready, !s_ready, "word taken while busy")
    `SSB_ASSERT_IMP(a_online_state, m_valid && m_went_online, m_state_now == ST_ONLINE, "online flag off online")
    `SSB_ASSERT_IMP(a_start_state, m_valid && m_command == CMD_START, m_state_now == ST_START, "start command outside starting")
    `SSB_ASSERT_NXT(a_fail_sat, fail_cnt_reg == FAIL_SAT, fail_cnt_reg == FAIL_SAT || fail_cnt_reg == '0, "failure count wrapped")
    `SSB_ASSERT_IMP(a_jit_owned, jit_rsp.busy, fsm_reg == T_JIT, "backoff unit busy outside wait")

endmodule

`default_nettype wire
